### sv/vbrs_pkg.sv
// Types and constants shared by the variable-block ring store modules.
package vbrs_pkg;

	localparam int POS_W  = 11;
	localparam int LEN_W  = 10;
	localparam int DATA_W = 8;
	localparam int MODE_W = 3;

	// Every block starts with a two-byte little-endian length header.
	localparam logic [POS_W-1:0] HDR_BYTES = 11'd2;

	// Value of the ring_size register after reset.
	localparam logic [POS_W-1:0] RING_SIZE_RST = 11'd1024;

	// Register index of ring_size on the configuration port.
	localparam logic REG_RING_SIZE = 1'b0;

	// Item operation codes.
	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FREE    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HDR_HI,
		ST_HEAD,
		ST_DATA,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  block_len;
		logic [LEN_W-1:0]  byte_offset;
		logic [DATA_W-1:0] byte_in;
	} item_t;

	typedef struct packed {
		logic              ok;
		logic [LEN_W-1:0]  block_start;
		logic [LEN_W-1:0]  head_len;
		logic [DATA_W-1:0] byte_out;
		logic [POS_W-1:0]  free_bytes;
	} result_t;

	typedef struct packed {
		logic             wr;
		logic [POS_W-1:0] ring_size;
	} cfg_wr_t;

endpackage

### sv/vbrs_mem.sv
// Byte memory with one write port and two registered read ports.
module vbrs_mem #(
	parameter int MEM_BYTES = 1024,
	localparam int AW = $clog2(MEM_BYTES)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [vbrs_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr_a,
	input  logic [AW-1:0]              raddr_b,
	output logic [vbrs_pkg::DATA_W-1:0] rdata_a,
	output logic [vbrs_pkg::DATA_W-1:0] rdata_b
);

	logic [vbrs_pkg::DATA_W-1:0] mem [MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### sv/vbrs_ctrl.sv
// Sequencer that keeps the ring pointers and drives the byte memory.
module vbrs_ctrl #(
	parameter int MEM_BYTES = 1024,
	localparam int AW = $clog2(MEM_BYTES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vbrs_pkg::cfg_wr_t           cfg,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  vbrs_pkg::item_t             item,
	input  logic                        out_free,
	output logic                        done,
	output vbrs_pkg::result_t           res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [vbrs_pkg::DATA_W-1:0] mem_wdata,
	output logic [AW-1:0]               mem_raddr_a,
	output logic [AW-1:0]               mem_raddr_b,
	input  logic [vbrs_pkg::DATA_W-1:0] mem_rdata_a,
	input  logic [vbrs_pkg::DATA_W-1:0] mem_rdata_b
);

	localparam int PW = vbrs_pkg::POS_W;
	localparam int XW = (AW + 1 > 13) ? AW + 1 : 13;
	localparam int CAP_I = (MEM_BYTES > 2047) ? 2047 : MEM_BYTES;
	localparam logic [PW-1:0] MEM_CAP = PW'(CAP_I);

	function automatic logic [PW-1:0] eff_size(input logic [PW-1:0] v);
		return (v > MEM_CAP) ? MEM_CAP : v;
	endfunction

	// Addresses stay below the ring size in use; the fold only guards the wrap.
	function automatic logic [AW-1:0] mem_addr(input logic [PW:0] a);
		logic [XW-1:0] x;
		x = XW'(a);
		if (x >= XW'(MEM_BYTES)) begin
			x = x - XW'(MEM_BYTES);
		end
		return x[AW-1:0];
	endfunction

	vbrs_pkg::state_t  state_q, state_d;
	vbrs_pkg::item_t   item_q;
	vbrs_pkg::result_t hold_q, res_d;

	logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, wrap_q, wrap_d;
	logic [PW-1:0] free_q, free_d, size_q, oblk_q, oblk_d;
	logic [vbrs_pkg::LEN_W-1:0] olen_q, olen_d;
	logic fin;

	logic [PW-1:0] tot, start, rp_fw, np_fw;
	logic [PW:0]   end_sum, np;
	logic [vbrs_pkg::LEN_W-1:0] hlen;
	logic fits_free, fits_end, fits_wrap, empty, wrap_hit, np_hit;

	assign tot       = PW'(item_q.block_len) + vbrs_pkg::HDR_BYTES;
	assign end_sum   = {1'b0, wp_q} + {1'b0, tot};
	assign fits_free = (tot <= free_q);
	assign fits_end  = (end_sum <= {1'b0, size_q});
	assign fits_wrap = (tot <= rp_q);
	assign start     = fits_end ? wp_q : '0;
	assign empty     = (free_q == size_q);
	assign wrap_hit  = (rp_q == wrap_q) && (wrap_q != '0);
	assign rp_fw     = wrap_hit ? '0 : rp_q;
	assign hlen      = {mem_rdata_b[1:0], mem_rdata_a};
	assign np        = {1'b0, rp_q} + (PW + 1)'(hlen) + {1'b0, vbrs_pkg::HDR_BYTES};
	assign np_hit    = (np == {1'b0, wrap_q}) && (wrap_q != '0);
	assign np_fw     = np_hit ? '0 : np[PW-1:0];

	assign req_stall = (state_q != vbrs_pkg::ST_IDLE);

	always_comb begin
		state_d     = state_q;
		wp_d        = wp_q;
		rp_d        = rp_q;
		wrap_d      = wrap_q;
		free_d      = free_q;
		oblk_d      = oblk_q;
		olen_d      = olen_q;
		fin         = 1'b0;
		res_d       = '0;
		mem_we      = 1'b0;
		mem_waddr   = mem_addr({1'b0, oblk_q});
		mem_wdata   = item_q.byte_in;
		mem_raddr_a = mem_addr({1'b0, rp_fw});
		mem_raddr_b = mem_addr({1'b0, rp_fw} + (PW + 1)'(1));
		unique case (state_q)
			vbrs_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = vbrs_pkg::ST_EXEC;
				end
			end
			vbrs_pkg::ST_EXEC: begin
				unique case (item_q.mode)
					vbrs_pkg::MODE_RESERVE: begin
						if (fits_free && (fits_end || fits_wrap)) begin
							if (fits_end) begin
								wp_d   = end_sum[PW-1:0];
								free_d = free_q - tot;
							end else begin
								wrap_d = wp_q;
								wp_d   = tot;
								free_d = rp_q - tot;
							end
							oblk_d    = start;
							olen_d    = item_q.block_len;
							mem_we    = 1'b1;
							mem_waddr = mem_addr({1'b0, start});
							mem_wdata = item_q.block_len[7:0];
							state_d   = vbrs_pkg::ST_HDR_HI;
						end else begin
							fin = 1'b1;
						end
					end
					vbrs_pkg::MODE_WRITE: begin
						if (item_q.byte_offset < olen_q) begin
							mem_we    = 1'b1;
							mem_waddr = mem_addr({1'b0, oblk_q} + {1'b0, vbrs_pkg::HDR_BYTES}
								+ (PW + 1)'(item_q.byte_offset));
							res_d.ok          = 1'b1;
							res_d.block_start = oblk_q[vbrs_pkg::LEN_W-1:0];
						end
						fin = 1'b1;
					end
					vbrs_pkg::MODE_PEEK, vbrs_pkg::MODE_READ, vbrs_pkg::MODE_FREE: begin
						if (empty) begin
							fin = 1'b1;
						end else begin
							rp_d = rp_fw;
							if (wrap_hit) begin
								wrap_d = '0;
							end
							state_d = vbrs_pkg::ST_HEAD;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			vbrs_pkg::ST_HDR_HI: begin
				mem_we            = 1'b1;
				mem_waddr         = mem_addr({1'b0, oblk_q} + (PW + 1)'(1));
				mem_wdata         = vbrs_pkg::DATA_W'(olen_q[vbrs_pkg::LEN_W-1:8]);
				res_d.ok          = 1'b1;
				res_d.block_start = oblk_q[vbrs_pkg::LEN_W-1:0];
				fin               = 1'b1;
			end
			vbrs_pkg::ST_HEAD: begin
				unique case (item_q.mode)
					vbrs_pkg::MODE_PEEK: begin
						res_d.ok          = 1'b1;
						res_d.block_start = rp_q[vbrs_pkg::LEN_W-1:0];
						res_d.head_len    = hlen;
						fin               = 1'b1;
					end
					vbrs_pkg::MODE_READ: begin
						if (item_q.byte_offset < hlen) begin
							mem_raddr_a = mem_addr({1'b0, rp_q} + {1'b0, vbrs_pkg::HDR_BYTES}
								+ (PW + 1)'(item_q.byte_offset));
							state_d = vbrs_pkg::ST_DATA;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						res_d.ok          = 1'b1;
						res_d.block_start = rp_q[vbrs_pkg::LEN_W-1:0];
						if (np_fw == wp_q) begin
							rp_d   = '0;
							wp_d   = '0;
							wrap_d = '0;
							free_d = size_q;
							oblk_d = '0;
							olen_d = '0;
						end else begin
							rp_d = np_fw;
							if (np_hit) begin
								wrap_d = '0;
							end
							if (np_fw < wp_q) begin
								free_d = size_q - wp_q + np_fw;
							end else begin
								free_d = np_fw - wp_q;
							end
						end
						fin = 1'b1;
					end
				endcase
			end
			vbrs_pkg::ST_DATA: begin
				res_d.ok          = 1'b1;
				res_d.block_start = rp_q[vbrs_pkg::LEN_W-1:0];
				res_d.byte_out    = mem_rdata_a;
				fin               = 1'b1;
			end
			vbrs_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = vbrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vbrs_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? vbrs_pkg::ST_IDLE : vbrs_pkg::ST_PUSH;
		end
		res_d.free_bytes = free_d;
	end

	assign done = out_free && (fin || (state_q == vbrs_pkg::ST_PUSH));
	assign res  = (state_q == vbrs_pkg::ST_PUSH) ? hold_q : res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			wrap_q <= '0;
			free_q <= eff_size(vbrs_pkg::RING_SIZE_RST);
			size_q <= eff_size(vbrs_pkg::RING_SIZE_RST);
			oblk_q <= '0;
			olen_q <= '0;
		end else if (cfg.wr) begin
			wp_q   <= '0;
			rp_q   <= '0;
			wrap_q <= '0;
			free_q <= eff_size(cfg.ring_size);
			size_q <= eff_size(cfg.ring_size);
			oblk_q <= '0;
			olen_q <= '0;
		end else begin
			wp_q   <= wp_d;
			rp_q   <= rp_d;
			wrap_q <= wrap_d;
			free_q <= free_d;
			oblk_q <= oblk_d;
			olen_q <= olen_d;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == vbrs_pkg::ST_IDLE) && req_valid) begin
			item_q <= item;
		end
		if (fin && !out_free) begin
			hold_q <= res_d;
		end
	end

endmodule

### sv/variable_block_ring_store_top.sv
// Top level of the variable-block ring store: configuration port, item channels, result register.
//
// This block keeps a FIFO of variable-length blocks in a byte memory of MEM_BYTES bytes, each
// block stored contiguously as a two-byte little-endian length header and its payload. An item
// either reserves a block (mode 0), writes a payload byte into the last reserved block (mode 1),
// peeks at the head block (mode 2), reads a head payload byte (mode 3) or frees the head block
// (mode 4); every item yields exactly one result. The block works on one item at a time. An
// item is latched while idle and executed in ST_EXEC, which finishes a payload write, a refused
// reservation or write, an unknown mode or an access to an empty store. A reservation writes the
// low header byte there and the high one in ST_HDR_HI (the single memory write port stores the
// two header bytes one after the other); a peek or a free finishes in ST_HEAD, as the header
// read is registered; a payload read, which needs the header length before it can address the
// byte, is refused in ST_HEAD if the offset is past that length and else finishes in ST_DATA.
// The next item is taken in the cycle after the result is registered; a result still waiting
// downstream does not block acceptance, only the delivery of the following result. The memory
// needs no clearing pass after reset, and the ring_size register (byte address 0) must be
// written only while no item is in flight; writing it empties the store.
module variable_block_ring_store_top #(
	parameter int MEM_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Item channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  mode,
	input  logic [9:0]  block_len,
	input  logic [9:0]  byte_offset,
	input  logic [7:0]  byte_in,
	// Result channel.
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        ok,
	output logic [9:0]  block_start,
	output logic [9:0]  head_len,
	output logic [7:0]  byte_out,
	output logic [10:0] free_bytes
);

	localparam int AW = $clog2(MEM_BYTES);

	vbrs_pkg::cfg_wr_t cfg;
	vbrs_pkg::item_t   item;
	vbrs_pkg::result_t res, rsp_q;

	logic [vbrs_pkg::POS_W-1:0] ring_size_q;
	logic rsp_valid_q, out_free, done;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [vbrs_pkg::DATA_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	// The register index is the word address; only index zero exists.
	assign pready        = 1'b1;
	assign cfg.wr        = psel && penable && pwrite && (paddr[2] == vbrs_pkg::REG_RING_SIZE);
	assign cfg.ring_size = pwdata[vbrs_pkg::POS_W-1:0];
	assign prdata        = (paddr[2] == vbrs_pkg::REG_RING_SIZE) ? 32'(ring_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= vbrs_pkg::RING_SIZE_RST;
		end else if (cfg.wr) begin
			ring_size_q <= cfg.ring_size;
		end
	end

	assign item.mode        = mode;
	assign item.block_len   = block_len;
	assign item.byte_offset = byte_offset;
	assign item.byte_in     = byte_in;

	// The output register can take a new result when it is empty or being emptied.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign ok          = rsp_q.ok;
	assign block_start = rsp_q.block_start;
	assign head_len    = rsp_q.head_len;
	assign byte_out    = rsp_q.byte_out;
	assign free_bytes  = rsp_q.free_bytes;

	vbrs_ctrl #(
		.MEM_BYTES(MEM_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.item        (item),
		.out_free    (out_free),
		.done        (done),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	vbrs_mem #(
		.MEM_BYTES(MEM_BYTES)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

endmodule

### sv/vbrs_checker.sv
// Port-level checks for the variable-block ring store and their binding to the top level.
module vbrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        ok,
	input logic [9:0]  block_start,
	input logic [9:0]  head_len,
	input logic [7:0]  byte_out,
	input logic [10:0] free_bytes
);

	// A held result keeps its contents until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(ok) && $stable(block_start)
			&& $stable(head_len) && $stable(byte_out) && $stable(free_bytes)))
		else $error("held result changed");

	// A failed item reports no block, no length and no byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !ok) |-> (block_start == '0 && head_len == '0 && byte_out == '0))
		else $error("failed item carries data");

	// Items are handled one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second item taken while one is in flight");

	// No result can appear in the cycle right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !$rose(rsp_valid))
		else $error("result appeared too early");

endmodule

bind variable_block_ring_store_top vbrs_checker u_vbrs_checker (.*);
